@@ design/ptrs_pkg.sv @@
// ----------------------------------------------------------------------------
// ptrs_pkg : shared definitions for the palette-to-RGB scanout converter
// Source geometry, register indexes, pixel format codes, the 16-color
// palette tables and the pixel record passed between pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package ptrs_pkg;

  // Source image geometry
  localparam int unsigned SrcWidth  = 640;
  localparam int unsigned SrcHeight = 480;
  localparam int unsigned ColW      = 10;
  localparam int unsigned RowW      = 9;

  // Configuration register indexes
  localparam logic [2:0] REG_OUTPUT_ENABLE  = 3'd0;
  localparam logic [2:0] REG_BASE_ADDRESS   = 3'd1;
  localparam logic [2:0] REG_LINE_PITCH     = 3'd2;
  localparam logic [2:0] REG_DISPLAY_WIDTH  = 3'd3;
  localparam logic [2:0] REG_DISPLAY_HEIGHT = 3'd4;
  localparam logic [2:0] REG_PIXEL_FORMAT   = 3'd5;

  // Pixel format codes
  localparam logic [1:0] FMT_RGB565 = 2'd0;
  localparam logic [1:0] FMT_RGB888 = 2'd1;
  localparam logic [1:0] FMT_XRGB32 = 2'd2;
  localparam logic [1:0] FMT_NONE   = 2'd3;

  // Byte counts per format
  localparam logic [2:0] BYTES_16 = 3'd2;
  localparam logic [2:0] BYTES_24 = 3'd3;
  localparam logic [2:0] BYTES_32 = 3'd4;

  // One visible pixel after position tracking
  typedef struct packed {
    logic [3:0]      color;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
  } pix_t;

  // 16-color palette in RGB565
  function automatic logic [15:0] pal565(input logic [3:0] color);
    logic [15:0] v;
    case (color)
      4'h0:    v = 16'h0000;
      4'h1:    v = 16'h001F;
      4'h2:    v = 16'h07E0;
      4'h3:    v = 16'h07FF;
      4'h4:    v = 16'hF800;
      4'h5:    v = 16'hF81F;
      4'h6:    v = 16'hA145;
      4'h7:    v = 16'hC618;
      4'h8:    v = 16'h4208;
      4'h9:    v = 16'h3C7F;
      4'hA:    v = 16'h87E0;
      4'hB:    v = 16'h87FF;
      4'hC:    v = 16'hFC10;
      4'hD:    v = 16'hFC1F;
      4'hE:    v = 16'hFFE0;
      default: v = 16'hFFFF;
    endcase
    return v;
  endfunction

  // 16-color palette in RGB888
  function automatic logic [23:0] pal888(input logic [3:0] color);
    logic [23:0] v;
    case (color)
      4'h0:    v = 24'h000000;
      4'h1:    v = 24'h0000AA;
      4'h2:    v = 24'h00AA00;
      4'h3:    v = 24'h00AAAA;
      4'h4:    v = 24'hAA0000;
      4'h5:    v = 24'hAA00AA;
      4'h6:    v = 24'hAA5500;
      4'h7:    v = 24'hAAAAAA;
      4'h8:    v = 24'h555555;
      4'h9:    v = 24'h5555FF;
      4'hA:    v = 24'h55FF55;
      4'hB:    v = 24'h55FFFF;
      4'hC:    v = 24'hFF5555;
      4'hD:    v = 24'hFF55FF;
      4'hE:    v = 24'hFFFF55;
      default: v = 24'hFFFFFF;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ design/ptrs_pixel_expand.sv @@
// ----------------------------------------------------------------------------
// ptrs_pixel_expand : palette color to framebuffer word
// Expands a 4-bit palette color to the selected output format and gives
// the byte count and the byte offset of the pixel within its row.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrs_pixel_expand (
  input  wire logic [1:0]               format_i,
  input  wire logic [3:0]               color_i,
  input  wire logic [ptrs_pkg::ColW-1:0] col_i,
  output logic      [31:0]              data_o,
  output logic      [2:0]               byte_count_o,
  output logic      [ptrs_pkg::ColW+1:0] col_offset_o
);
  import ptrs_pkg::*;

  logic [ColW+1:0] col_x2;
  logic [ColW+1:0] col_x4;

  assign col_x2 = {1'b0, col_i, 1'b0};
  assign col_x4 = {col_i, 2'b00};

  // Select palette entry, size and column offset by format
  always_comb begin
    case (format_i)
      FMT_RGB565: begin
        data_o       = {16'h0000, pal565(color_i)};
        byte_count_o = BYTES_16;
        col_offset_o = col_x2;
      end
      FMT_RGB888: begin
        data_o       = {8'h00, pal888(color_i)};
        byte_count_o = BYTES_24;
        col_offset_o = col_x2 + {2'b00, col_i};
      end
      default: begin
        data_o       = {8'h00, pal888(color_i)};
        byte_count_o = BYTES_32;
        col_offset_o = col_x4;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/palette_to_rgb_scanout_converter_core.sv @@
// ----------------------------------------------------------------------------
// palette_to_rgb_scanout_converter_core : palette pixel stream to writes
// Tracks raster position of a 640x480 palette stream and turns each visible
// pixel into one framebuffer write (address, expanded data, byte count).
// ----------------------------------------------------------------------------
// An input is registered in stage one, then in the result (output) register.
// Throughput: one pixel per cycle; a two-stage register pipeline (position
// stage, then address/expand stage) stalls only when both stages are full.
// Clipped or suppressed pixels advance the position and leave at stage one.
// Reset: rst_ni clears the pipeline valids, position to (0,0) and loads the
// register defaults (writes off, format unsupported, display 640x480).
`default_nettype none

module palette_to_rgb_scanout_converter_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  // Pixel input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] palette_pixel
  input  wire logic        s_axis_tuser,   // [0] frame_start
  // Framebuffer write stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [71:0] m_axis_tdata    // [31:0] write_address,
                                           // [63:32] write_data,
                                           // [66:64] byte_count, [71:67] zero
);
  import ptrs_pkg::*;

  // Configuration registers
  logic        out_en_q;
  logic [31:0] base_q;
  logic [15:0] pitch_q;
  logic [15:0] disp_w_q;
  logic [15:0] disp_h_q;
  logic [1:0]  format_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_en_q <= 1'b0;
      base_q   <= 32'd0;
      pitch_q  <= 16'd0;
      disp_w_q <= 16'(SrcWidth);
      disp_h_q <= 16'(SrcHeight);
      format_q <= FMT_NONE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_OUTPUT_ENABLE:  out_en_q <= cfg_wdata_i[0];
        REG_BASE_ADDRESS:   base_q   <= cfg_wdata_i;
        REG_LINE_PITCH:     pitch_q  <= cfg_wdata_i[15:0];
        REG_DISPLAY_WIDTH:  disp_w_q <= cfg_wdata_i[15:0];
        REG_DISPLAY_HEIGHT: disp_h_q <= cfg_wdata_i[15:0];
        REG_PIXEL_FORMAT:   format_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic s1_valid_q, s1_valid_d;
  logic s2_ready;
  logic s1_ready;
  logic in_xfer;

  assign s2_ready      = !m_axis_tvalid || m_axis_tready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign in_xfer       = s_axis_tvalid && s1_ready;

  // Position tracking
  logic [ColW-1:0] col_q, col_d, col_cur;
  logic [RowW-1:0] row_q, row_d, row_cur;
  logic [ColW:0]   col_inc;
  logic [RowW:0]   row_inc;
  logic            visible;
  logic            emit;

  assign col_cur = s_axis_tuser ? '0 : col_q;
  assign row_cur = s_axis_tuser ? '0 : row_q;
  assign col_inc = {1'b0, col_cur} + 1'b1;
  assign row_inc = {1'b0, row_cur} + 1'b1;

  always_comb begin
    col_d = col_inc[ColW-1:0];
    row_d = row_cur;
    if (col_inc >= (ColW+1)'(SrcWidth)) begin
      col_d = '0;
      row_d = row_inc[RowW-1:0];
      if (row_inc >= (RowW+1)'(SrcHeight)) begin
        row_d = '0;
      end
    end
  end

  // Position never reaches the source size, so the display bound alone clips
  assign visible = ({{(16-ColW){1'b0}}, col_cur} < disp_w_q) &&
                   ({{(16-RowW){1'b0}}, row_cur} < disp_h_q);
  assign emit    = visible && out_en_q && (format_q != FMT_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage one: hold the visible pixel
  pix_t s1_pix_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_ready) begin
      s1_valid_d = in_xfer && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pix_q <= '{color: s_axis_tdata[3:0], col: col_cur, row: row_cur};
    end
  end

  // Stage two: expand color and form the byte address
  logic [31:0]     px_data;
  logic [2:0]      px_bytes;
  logic [ColW+1:0] col_off;
  logic [RowW+15:0] row_off;
  logic [31:0]     addr;

  ptrs_pixel_expand u_expand (
    .format_i     (format_q),
    .color_i      (s1_pix_q.color),
    .col_i        (s1_pix_q.col),
    .data_o       (px_data),
    .byte_count_o (px_bytes),
    .col_offset_o (col_off)
  );

  assign row_off = s1_pix_q.row * pitch_q;
  assign addr    = base_q + {{(32-RowW-16){1'b0}}, row_off}
                          + {{(32-ColW-2){1'b0}}, col_off};

  // Result register
  logic m_valid_q, m_valid_d;
  logic [71:0] m_data_q;

  always_comb begin
    m_valid_d = m_valid_q;
    if (s2_ready) begin
      m_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      m_data_q <= {5'b00000, px_bytes, px_data, addr};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

@@ design/ptrs_checker.sv @@
// ----------------------------------------------------------------------------
// ptrs_checker : port-level checks for the scanout converter
// Watches the streams of the core and checks reset, stall, consistency of
// byte count and data width, and output after input; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata
);

  // No output once reset has been seen at an edge
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // Hold a stalled transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transfer changed");

  // Byte count is one of the three sizes, padding is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[66:64] == 3'd2 || m_axis_tdata[66:64] == 3'd3 ||
                       m_axis_tdata[66:64] == 3'd4) && m_axis_tdata[71:67] == 5'd0)
    else $error("bad byte count");

  // Data bytes beyond the byte count are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[66:64] != 3'd4 |->
      m_axis_tdata[63:56] == 8'd0 &&
      (m_axis_tdata[66:64] != 3'd2 || m_axis_tdata[55:48] == 8'd0))
    else $error("data wider than byte count");

  // Output only follows an earlier input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("output without input transfer");

endmodule

bind palette_to_rgb_scanout_converter_core ptrs_checker u_ptrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
